// ----- rtl/core/cas_pkg.sv -----
// ----------------------------------------------------------------------------
// cas_pkg
// Shared types and constants of the cave automaton step block.
// ----------------------------------------------------------------------------
package cas_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam logic [7:0] GRID_WIDTH_RST  = 8'd100;
  localparam logic [7:0] GRID_HEIGHT_RST = 8'd100;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_RULE_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd2;

  localparam logic [1:0] CELL_EMPTY  = 2'd0;
  localparam logic [1:0] CELL_WALL   = 2'd1;
  localparam logic [1:0] CELL_BORDER = 2'd2;

  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam logic MODE_GROWTH = 1'b0;
  localparam logic MODE_SMOOTH = 1'b1;

  typedef struct packed {
    logic       action;
    logic [1:0] cell_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0] cell_out;
    logic [6:0] out_row;
    logic [6:0] out_col;
    logic       frame_end;
  } out_item_t;

endpackage

// ----- rtl/core/cave_automaton_step.sv -----
// ----------------------------------------------------------------------------
// cave_automaton_step
// One generation of a 3x3 cave cellular automaton over a raster cell stream.
// ----------------------------------------------------------------------------
// Pipeline: history RAM read and rule stage registers, then the output register.
// Throughput: one cell per cycle while not stalled; the first W+1 items of a frame give no result.
// Reset clears position, row taps, fill count, pipeline valids and config.
// History RAM is not swept: a fill count masks entries not yet written.
module cave_automaton_step
  import cas_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CW       = $clog2(MAX_WIDTH + 1);
  localparam int HW       = $clog2(MAX_HEIGHT + 1);
  localparam int RW       = $clog2(MAX_HEIGHT + 3);
  localparam int AW       = $clog2(2 * MAX_WIDTH + 1);
  localparam int DEPTH    = 1 << AW;
  localparam int FILL_MAX = 2 * MAX_WIDTH + 1;
  localparam int FW       = $clog2(FILL_MAX + 1);

  // config
  logic       rule_mode_r;
  logic [7:0] grid_width_r;
  logic [7:0] grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rule_mode_r   <= MODE_GROWTH;
      grid_width_r  <= GRID_WIDTH_RST;
      grid_height_r <= GRID_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE_MODE:   rule_mode_r   <= cfg_wdata[0];
        CFG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        CFG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] w_c;
  logic [HW-1:0] h_c;

  always_comb begin
    if (grid_width_r < 8'd3) begin
      w_c = CW'(3);
    end else if (int'(grid_width_r) > MAX_WIDTH) begin
      w_c = CW'(MAX_WIDTH);
    end else begin
      w_c = CW'(grid_width_r);
    end
    if (grid_height_r < 8'd3) begin
      h_c = HW'(3);
    end else if (int'(grid_height_r) > MAX_HEIGHT) begin
      h_c = HW'(MAX_HEIGHT);
    end else begin
      h_c = HW'(grid_height_r);
    end
  end

  // handshake
  logic p1_v_r, out_v_r;
  logic o_load, accept;

  assign o_load   = !out_v_r || !out_stall;
  assign in_stall = p1_v_r && !o_load;
  assign accept   = in_valid && !in_stall;

  // input stage
  logic [RW-1:0] pos_row_r, pos_row_nxt;
  logic [CW-1:0] pos_col_r, pos_col_nxt;
  logic [1:0]    s0_r, s1_r;
  logic [AW-1:0] head_r;
  logic [FW-1:0] fill_r;

  logic [RW-1:0] row_a, orow_a;
  logic [CW-1:0] col_a, ocol_a;
  logic [RW-1:0] h_r1;
  logic [1:0]    cell_a;
  logic          emit_a, border_a, last_a;
  logic          mid_ok_a, top_ok_a;
  logic [AW-1:0] w_a;

  always_comb begin
    h_r1   = RW'(h_c) + RW'(1);
    row_a  = pos_row_r;
    col_a  = pos_col_r;
    if (col_a >= w_c) begin
      col_a = '0;
      row_a = row_a + RW'(1);
    end
    if (row_a > h_r1 || (row_a == h_r1 && col_a != '0)) begin
      row_a = '0;
      col_a = '0;
    end

    cell_a = (in_data.action == ACT_FLUSH) ? CELL_EMPTY : in_data.cell_in;
    emit_a = (row_a >= RW'(1)) && (col_a >= CW'(1) || row_a >= RW'(2));

    if (col_a != '0) begin
      orow_a = row_a - RW'(1);
      ocol_a = col_a - CW'(1);
    end else begin
      orow_a = row_a - RW'(2);
      ocol_a = w_c - CW'(1);
    end

    border_a = (orow_a == '0) || (orow_a == RW'(h_c) - RW'(1))
            || (ocol_a == '0) || (ocol_a == w_c - CW'(1));
    last_a   = (orow_a == RW'(h_c) - RW'(1)) && (ocol_a == w_c - CW'(1));

    pos_col_nxt = col_a + CW'(1);
    pos_row_nxt = row_a;
    if (pos_col_nxt >= w_c) begin
      pos_col_nxt = '0;
      pos_row_nxt = row_a + RW'(1);
    end
    if (emit_a && last_a) begin
      pos_row_nxt = '0;
      pos_col_nxt = '0;
    end

    w_a      = AW'(w_c);
    mid_ok_a = int'(w_c) <= int'(fill_r);
    top_ok_a = 2 * int'(w_c) <= int'(fill_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_row_r <= '0;
      pos_col_r <= '0;
      s0_r      <= CELL_EMPTY;
      s1_r      <= CELL_EMPTY;
      head_r    <= '0;
      fill_r    <= '0;
    end else if (accept) begin
      pos_row_r <= pos_row_nxt;
      pos_col_r <= pos_col_nxt;
      s0_r      <= cell_a;
      s1_r      <= s0_r;
      head_r    <= head_r + AW'(1);
      if (int'(fill_r) < FILL_MAX) begin
        fill_r <= fill_r + FW'(1);
      end
    end
  end

  // history: each entry holds the newest cell and the two before it
  logic [5:0] mid_rd, top_rd;

  cas_ram #(
    .WIDTH(6),
    .DEPTH(DEPTH)
  ) u_hist (
    .clk    (clk),
    .we     (accept),
    .waddr  (head_r),
    .wdata  ({cell_a, s0_r, s1_r}),
    .re     (accept),
    .raddr_a(head_r - w_a),
    .raddr_b(head_r - (w_a << 1)),
    .rdata_a(mid_rd),
    .rdata_b(top_rd)
  );

  // rule stage
  logic       p1_emit_r, p1_border_r, p1_last_r, p1_mid_ok_r, p1_top_ok_r;
  logic [6:0] p1_row_r, p1_col_r;
  logic [5:0] p1_bot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (accept) begin
      p1_v_r <= 1'b1;
    end else if (o_load) begin
      p1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p1_emit_r   <= emit_a;
      p1_border_r <= border_a;
      p1_last_r   <= last_a;
      p1_mid_ok_r <= mid_ok_a;
      p1_top_ok_r <= top_ok_a;
      p1_row_r    <= 7'(orow_a);
      p1_col_r    <= 7'(ocol_a);
      p1_bot_r    <= {cell_a, s0_r, s1_r};
    end
  end

  logic [5:0] mid_t, top_t;
  logic [3:0] count;
  logic [1:0] centre, res;

  always_comb begin
    mid_t  = p1_mid_ok_r ? mid_rd : '0;
    top_t  = p1_top_ok_r ? top_rd : '0;
    centre = mid_t[3:2];
    count  = 4'(top_t[1:0] == CELL_WALL) + 4'(top_t[3:2] == CELL_WALL)
           + 4'(top_t[5:4] == CELL_WALL) + 4'(mid_t[1:0] == CELL_WALL)
           + 4'(mid_t[5:4] == CELL_WALL) + 4'(p1_bot_r[1:0] == CELL_WALL)
           + 4'(p1_bot_r[3:2] == CELL_WALL) + 4'(p1_bot_r[5:4] == CELL_WALL);
    if (p1_border_r) begin
      res = CELL_BORDER;
    end else if (rule_mode_r == MODE_GROWTH) begin
      res = (count == 4'd2 || count == 4'd3) ? CELL_WALL : CELL_EMPTY;
    end else if (centre == CELL_WALL) begin
      res = (count < 4'd3) ? CELL_EMPTY : CELL_WALL;
    end else if (centre == CELL_EMPTY) begin
      res = (count > 4'd4) ? CELL_WALL : CELL_EMPTY;
    end else begin
      res = CELL_BORDER;
    end
  end

  // output register
  out_item_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (o_load) begin
      out_v_r <= p1_v_r && p1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load && p1_v_r) begin
      out_data_r.cell_out  <= res;
      out_data_r.out_row   <= p1_row_r;
      out_data_r.out_col   <= p1_col_r;
      out_data_r.frame_end <= p1_last_r;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/cas_ram.sv -----
// ----------------------------------------------------------------------------
// cas_ram
// Simple dual-read RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module cas_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/core/cas_checker.sv -----
// ----------------------------------------------------------------------------
// cas_checker
// Port-level checks of the cave automaton step block, bound to the top level.
// ----------------------------------------------------------------------------
module cas_checker
  import cas_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_end_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |-> out_data.cell_out == CELL_BORDER)
    else $error("frame end cell not border");

  a_cell_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cell_out == CELL_EMPTY || out_data.cell_out == CELL_WALL
               || out_data.cell_out == CELL_BORDER)
    else $error("illegal cell code out");

endmodule

bind cave_automaton_step cas_checker u_cas_checker (.*);
